[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define MIE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Clocked property, checked during reset too.
`define MIE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define MIE_ASSERT(lbl, clk, rst, prop)
`define MIE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/mie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_pkg
// Shared widths, status codes, controller/datapath bundles and helpers for
// the modular inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

  // operand width of the Euclid datapath (4 .. 64)
  localparam int WIDTH   = 32;
  // width of the transaction fields
  localparam int FIELD_W = 32;
  // signed coefficient width; |s| never exceeds the modulus
  localparam int SW      = WIDTH + 2;
  // division step counter
  localparam int CW      = $clog2(WIDTH);

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NOT_COPRIME = 2'd1;
  localparam logic [1:0] STATUS_ZERO_MOD    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul;
    logic upd;
    logic abs_s;
    logic mod_red;
    logic emit;
  } mie_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_zero;
    logic zero_mod;
    logic div_done;
  } mie_sts_t;

  // field bits -> operand bits (upper field bits dropped, zero fill above)
  function automatic logic [WIDTH-1:0] to_op(input logic [FIELD_W-1:0] v);
    logic [WIDTH-1:0] r;
    r = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (i < FIELD_W) r[i] = v[i];
    end
    return r;
  endfunction

  // operand bits -> field bits
  function automatic logic [FIELD_W-1:0] to_field(input logic [WIDTH-1:0] v);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (i < WIDTH) r[i] = v[i];
    end
    return r;
  endfunction

endpackage

[rtl/mie_op_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_op_if
// Operand channel: value and modulus with valid/ready.
// ----------------------------------------------------------------------------
interface mie_op_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_a;
  logic [31:0] modulus;

  modport source (output valid, output value_a, output modulus, input ready);
  modport sink   (input valid, input value_a, input modulus, output ready);
endinterface

[rtl/mie_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_res_if
// Result channel: inverse, gcd and status with valid/ready.
// ----------------------------------------------------------------------------
interface mie_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] inverse;
  logic [31:0] gcd_value;
  logic [1:0]  status;

  modport source (output valid, output inverse, output gcd_value, output status,
                  input ready);
  modport sink   (input valid, input inverse, input gcd_value, input status,
                  output ready);
endinterface

[rtl/mie_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_datapath
// Remainder and coefficient registers, restoring divider (one quotient bit
// per cycle), coefficient multiplier, final reduction and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mie_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mie_pkg::FIELD_W-1:0] value_a,
  input  logic [mie_pkg::FIELD_W-1:0] modulus,
  input  mie_pkg::mie_cmd_t           cmd,
  output mie_pkg::mie_sts_t           sts,
  output logic [mie_pkg::FIELD_W-1:0] inverse,
  output logic [mie_pkg::FIELD_W-1:0] gcd_value,
  output logic [1:0]                  status
);
  import mie_pkg::*;

  logic [WIDTH-1:0] r_prev, r_cur, n_reg;
  logic [SW-1:0]    s_prev, s_cur, prod, mag;
  logic [WIDTH-1:0] quo, rem, red;
  logic [CW-1:0]    cnt;
  logic             neg, zero_mod;

  logic [WIDTH:0]   trial;
  logic             fits;
  logic [WIDTH-1:0] op_a, op_n, inv_val;

  assign op_a = to_op(value_a);
  assign op_n = to_op(modulus);

  // restoring division step: shift in next dividend bit, try subtract
  assign trial = {rem, quo[WIDTH-1]};
  assign fits  = trial >= {1'b0, r_cur};

  // sign fix-up of the reduced coefficient
  assign inv_val = (neg && red != '0) ? n_reg - red : red;

  assign sts.cur_zero = (r_cur == '0);
  assign sts.zero_mod = zero_mod;
  assign sts.div_done = (cnt == CW'(WIDTH - 1));

  // remainder sequence and coefficients
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_prev   <= op_a;
      r_cur    <= op_n;
      n_reg    <= op_n;
      s_prev   <= SW'(1);
      s_cur    <= '0;
      zero_mod <= (op_n == '0);
      red      <= '0;
      neg      <= 1'b0;
    end
    if (cmd.upd) begin
      r_prev <= r_cur;
      r_cur  <= rem;
      s_prev <= s_cur;
      s_cur  <= s_prev - prod;
    end
    if (cmd.abs_s) begin
      neg <= s_prev[SW-1];
      mag <= s_prev[SW-1] ? SW'(0) - s_prev : s_prev;
    end
    if (cmd.mod_red) begin
      red <= (mag >= {2'b00, n_reg}) ? WIDTH'(mag - {2'b00, n_reg}) : mag[WIDTH-1:0];
    end
  end

  // serial divider and quotient times coefficient
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= r_prev;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[WIDTH-2:0], fits};
      rem <= fits ? WIDTH'(trial - {1'b0, r_cur}) : trial[WIDTH-1:0];
      cnt <= cnt + CW'(1);
    end
    if (cmd.mul) begin
      prod <= SW'({{(SW-WIDTH){1'b0}}, quo} * s_cur);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      inverse   <= to_field(inv_val);
      gcd_value <= to_field(r_prev);
      if (zero_mod) begin
        status <= STATUS_ZERO_MOD;
      end else if (r_prev == WIDTH'(1)) begin
        status <= STATUS_OK;
      end else begin
        status <= STATUS_NOT_COPRIME;
      end
    end
  end

  // checks
  `MIE_ASSERT(a_rem_below_divisor, clk, rst, cmd.div_step |=> rem < r_cur)
  `MIE_ASSERT(a_red_below_mod, clk, rst, cmd.mod_red |=> red < n_reg)

endmodule

[rtl/mie_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the Euclid loop: load, per-step divide / multiply / update,
// final reduction, and the result register's valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mie_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mie_pkg::mie_sts_t  sts,
  output mie_pkg::mie_cmd_t  cmd
);
  import mie_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_MUL    = 8'b0000_1000,
    ST_UPD    = 8'b0001_0000,
    ST_ABS    = 8'b0010_0000,
    ST_MOD    = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   acc_in;

  assign op_ready = (state == ST_IDLE);
  assign acc_in   = op_valid && op_ready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (acc_in) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.zero_mod) begin
          state_next = ST_FINISH;
        end else if (sts.cur_zero) begin
          state_next = ST_ABS;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_ABS: begin
        cmd.abs_s  = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_red = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `MIE_ASSERT(a_emit_slot_free, clk, rst, cmd.emit |-> (!out_valid || out_ready))
  `MIE_ASSERT(a_div_to_mul, clk, rst, (state == ST_DIV && sts.div_done) |=> state == ST_MUL)
  `MIE_ASSERT(a_accept_starts, clk, rst, acc_in |=> state == ST_CHECK)
  `MIE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !out_valid))

endmodule

[rtl/modular_inverse_euclid.sv]
`timescale 1ns / 1ps
// From accepted operands to result: load, then per Euclid step a check, the bit-serial divide,
// multiply and update, then a final check, sign fix and reduction; a zero modulus skips to emit.
// One transaction at a time: operands are accepted only while the sequencer is idle.
// The next operands are accepted while a finished result still waits in the output register.
// Reset (rst, synchronous) returns the sequencer to idle and clears the result valid.
// ----------------------------------------------------------------------------
// modular_inverse_euclid
// Modular inverse and gcd by the extended Euclidean algorithm, built as a
// sequencer plus a datapath with one serial divider used by every Euclid step.
// ----------------------------------------------------------------------------
module modular_inverse_euclid (
  input logic     clk,
  input logic     rst,
  mie_op_if.sink  op,
  mie_res_if.source res
);
  import mie_pkg::*;

  mie_cmd_t cmd;
  mie_sts_t sts;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op.valid),
    .op_ready  (op.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mie_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .value_a   (op.value_a),
    .modulus   (op.modulus),
    .cmd       (cmd),
    .sts       (sts),
    .inverse   (res.inverse),
    .gcd_value (res.gcd_value),
    .status    (res.status)
  );

endmodule

[verif/tb_modular_inverse_euclid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_euclid
// Self-checking bench for the Euclid modular inverse block. Operand pairs are
// queued by a stimulus process and sent by a clocked driver. Each accepted
// pair is run through an iterative extended-Euclid predictor at the block's
// operand width. A clocked monitor compares every result, field by field,
// with the oldest prediction. Both sides throttle at random, the receiver
// is held off once long enough to back the block up, and the sender drains
// the block between phases.
// ----------------------------------------------------------------------------
module tb_modular_inverse_euclid;
  import mie_pkg::*;

  typedef struct {
    logic [31:0] value_a;
    logic [31:0] modulus;
  } operand_pair_t;

  typedef struct {
    logic [31:0] inverse;
    logic [31:0] gcd_value;
    logic [1:0]  status;
  } inverse_result_t;

  localparam int RANDOM_PER_PHASE = 116;
  localparam int LONG_STALL       = 4000;
  localparam int TAIL_CYCLES      = 1700;

  logic clk = 1'b0;
  logic rst;

  mie_op_if  op_ch ();
  mie_res_if res_ch ();

  modular_inverse_euclid u_top (
    .clk (clk),
    .rst (rst),
    .op  (op_ch),
    .res (res_ch)
  );

  operand_pair_t   pending_ops[$];
  inverse_result_t expected_results[$];
  operand_pair_t   next_ops;
  inverse_result_t got;
  inverse_result_t want;

  int send_idle_pct = 12;
  int recv_idle_pct = 77;
  int fail_count    = 0;
  int stall_left    = 0;
  logic stall_req   = 1'b0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fibonacci number k (F1 = F2 = 1); consecutive pairs give the longest runs
  function automatic logic [31:0] fib(input int k);
    logic [63:0] f0, f1, t;
    f0 = 64'd0;
    f1 = 64'd1;
    for (int i = 1; i < k; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f1[31:0];
  endfunction

  // Extended Euclid on WIDTH-bit operands; coefficient kept in 64-bit
  // two's complement and reduced into 0 .. n-1 at the end
  function automatic inverse_result_t predict_inverse(input logic [31:0] a_in,
                                                      input logic [31:0] n_in);
    inverse_result_t r;
    logic [63:0] mask, a, n, prev_r, cur_r, prev_s, cur_s, q, t, neg, inv;
    mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
    a = {32'd0, a_in} & mask;
    n = {32'd0, n_in} & mask;
    if (n == 64'd0) begin
      r.inverse   = 32'd0;
      r.gcd_value = a[31:0];
      r.status    = STATUS_ZERO_MOD;
      return r;
    end
    prev_r = a;
    cur_r  = n;
    prev_s = 64'd1;
    cur_s  = 64'd0;
    while (cur_r != 64'd0) begin
      q      = prev_r / cur_r;
      t      = prev_r - q * cur_r;
      prev_r = cur_r;
      cur_r  = t;
      t      = prev_s - q * cur_s;
      prev_s = cur_s;
      cur_s  = t;
    end
    if (prev_s[63]) begin
      neg = (64'd0 - prev_s) % n;
      inv = (neg == 64'd0) ? 64'd0 : n - neg;
    end else begin
      inv = prev_s % n;
    end
    r.inverse   = inv[31:0];
    r.gcd_value = prev_r[31:0];
    r.status    = (prev_r == 64'd1) ? STATUS_OK : STATUS_NOT_COPRIME;
    return r;
  endfunction

  task automatic add_op(input logic [31:0] a, input logic [31:0] n);
    operand_pair_t p;
    p.value_a = a;
    p.modulus = n;
    pending_ops = {pending_ops, p};
  endtask

  // Random operand pair; mixes full-range, small, shared-factor, edge and
  // worst-case (Fibonacci) operands
  task automatic add_random_op();
    int kind, k;
    logic [31:0] g;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: add_op($urandom, $urandom);
      4: add_op($urandom_range(0, 255), $urandom_range(1, 255));
      5: begin
        g = $urandom_range(2, 1000);
        add_op(g * $urandom_range(0, 32'h001F_FFFF), g * $urandom_range(1, 32'h001F_FFFF));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: add_op($urandom, 32'd0);
          1: add_op($urandom, 32'd1);
          default: add_op(32'd0, $urandom);
        endcase
      end
      7: add_op(32'hFFFF_FFFF - $urandom_range(0, 15), 32'hFFFF_FFFF - $urandom_range(0, 15));
      8: begin
        k = $urandom_range(2, 46);
        if ($urandom_range(0, 1)) add_op(fib(k), fib(k + 1));
        else add_op(fib(k + 1), fib(k));
      end
      default: add_op($urandom, $urandom_range(1, 65535));
    endcase
  endtask

  // wait until every queued pair has been sent and every result returned
  task automatic wait_drained();
    while (pending_ops.size() != 0 || op_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Operand driver; predicts each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      op_ch.valid <= 1'b0;
    end else begin
      if (op_ch.valid && op_ch.ready)
        expected_results = {expected_results,
                            predict_inverse(op_ch.value_a, op_ch.modulus)};
      if (!op_ch.valid || op_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_ops = pending_ops.pop_front();
          op_ch.valid   <= 1'b1;
          op_ch.value_a <= next_ops.value_a;
          op_ch.modulus <= next_ops.modulus;
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_req) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.inverse   = res_ch.inverse;
        got.gcd_value = res_ch.gcd_value;
        got.status    = res_ch.status;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result inv=%h gcd=%h status=%0d",
                     got.inverse, got.gcd_value, got.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.inverse !== want.inverse || got.gcd_value !== want.gcd_value ||
              got.status !== want.status) begin
            if (fail_count < 10)
              $display({"ERROR: mismatch exp inv=%h gcd=%h status=%0d, ",
                        "got inv=%h gcd=%h status=%0d"},
                       want.inverse, want.gcd_value, want.status,
                       got.inverse, got.gcd_value, got.status);
            fail_count++;
          end
        end
      end
      res_ch.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    rst            = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero modulus
    add_op(32'd0, 32'd0);
    add_op(32'd5, 32'd0);
    add_op(32'hFFFF_FFFF, 32'd0);
    // modulus one
    add_op(32'd0, 32'd1);
    add_op(32'hFFFF_FFFF, 32'd1);
    add_op(32'd1, 32'd1);
    // zero value
    add_op(32'd0, 32'd7);
    add_op(32'd0, 32'hFFFF_FFFF);
    // coprime, small and at the top of the range
    add_op(32'd3, 32'd7);
    add_op(32'd1, 32'd2);
    add_op(32'd1, 32'hFFFF_FFFF);
    add_op(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    add_op(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    add_op(32'h8000_0000, 32'hFFFF_FFFF);
    add_op(32'd12345, 32'd65536);
    // value not below modulus
    add_op(32'd10, 32'd7);
    add_op(32'hFFFF_FFFF, 32'd3);
    // not coprime
    add_op(32'd6, 32'd9);
    add_op(32'd7, 32'd7);
    add_op(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(32'd2, 32'h8000_0000);
    // longest remainder chains
    add_op(fib(46), fib(47));
    add_op(fib(47), fib(46));
    // sender waits for the block to empty out
    wait_drained();

    // phase 1: sender mostly busy, receiver mostly idle, one long hold-off
    for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random_op();
    stall_req = 1'b1;
    @(negedge clk);
    stall_req = 1'b0;
    wait_drained();

    // phase 2: roles swapped
    send_idle_pct = 77;
    recv_idle_pct = 12;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random_op();
    wait_drained();

    // phase 3: no throttling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random_op();
    wait_drained();

    // catch any stray late result
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mie_pkg.sv
rtl/mie_op_if.sv
rtl/mie_res_if.sv
rtl/mie_datapath.sv
rtl/mie_ctrl.sv
rtl/modular_inverse_euclid.sv
verif/tb_modular_inverse_euclid.sv
